@@ design/vdw_pkg.sv @@
// Package with the shared widths, codes and constants of the volume displacement warp.
`default_nettype none

package vdw_pkg;

   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int DISP_W  = 22;
   localparam int SIZE_W  = 6;
   localparam int FRAC_W  = 16;
   localparam int WGT_W   = FRAC_W + 1;
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 26;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 61;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_WARP = 1'b1;

   typedef enum logic [1:0] {
      CSR_SIZE_X = 2'd0,
      CSR_SIZE_Y = 2'd1,
      CSR_SIZE_Z = 2'd2
   } csr_index_type;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
   localparam logic [WGT_W-1:0]  WEIGHT_ONE = 17'h10000;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = {{(ACC_W - 48){1'b0}}, 1'b1, 47'd0};

endpackage

`default_nettype wire

@@ design/vdw_req_if.sv @@
// Request channel interface carrying load and warp words.
`default_nettype none

interface vdw_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    opcode;
   logic        [vdw_pkg::POS_W-1:0]        pos_x;
   logic        [vdw_pkg::POS_W-1:0]        pos_y;
   logic        [vdw_pkg::POS_W-1:0]        pos_z;
   logic signed [vdw_pkg::VALUE_W-1:0]      voxel_value;
   logic signed [vdw_pkg::DISP_W-1:0]       disp_x;
   logic signed [vdw_pkg::DISP_W-1:0]       disp_y;
   logic signed [vdw_pkg::DISP_W-1:0]       disp_z;

   modport source (
      output valid, opcode, pos_x, pos_y, pos_z, voxel_value, disp_x, disp_y, disp_z,
      input  ready
   );

   modport sink (
      input  valid, opcode, pos_x, pos_y, pos_z, voxel_value, disp_x, disp_y, disp_z,
      output ready
   );
endinterface

`default_nettype wire

@@ design/vdw_rsp_if.sv @@
// Response channel interface carrying warped voxel words.
`default_nettype none

interface vdw_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [vdw_pkg::VALUE_W-1:0] warped_value;
   logic                               in_range;

   modport source (
      output valid, warped_value, in_range,
      input  ready
   );

   modport sink (
      input  valid, warped_value, in_range,
      output ready
   );
endinterface

`default_nettype wire

@@ design/vdw_ram.sv @@
// Generic RAM with one write port and one registered read port.
`default_nettype none

module vdw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/volume_displacement_warp.sv @@
// Top level of the volume displacement warp: voxel store, sequencer and shared multiplier.
//
// Words arrive on req_ch. A load word (opcode 0) writes voxel_value into the store at
// (pos_x, pos_y, pos_z) in the cycle it is accepted and produces no response; req_ch
// stays ready, so loads stream at one word per cycle. Positions outside the store are
// dropped. A warp word (opcode 1) drops ready until its response has been formed.
// A warp whose neighbour cube leaves the volume answers with in_range low and a zero
// value; its response is registered in the check step. A warp inside the volume
// reads its eight neighbours one at a time and runs four multiplications per
// neighbour through one shared 34 by 26 bit multiplier; its response is registered
// after the run, drain, sum and final steps, in the same cycle that ready returns.
// The sizes on the csr_ port may only change while no warp is in flight.
// Reset sets all three sizes to 32 and empties the response register; the store is
// not cleared and must be loaded before it is warped.
// A stalled response waits in the output register. Loads and a further warp are
// still accepted meanwhile; that warp holds in its last step until the register frees.
`default_nettype none

module volume_displacement_warp #(
   parameter int SIDE_X = 32,
   parameter int SIDE_Y = 32,
   parameter int SIDE_Z = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [vdw_pkg::SIZE_W-1:0]  csr_wr_data,
   vdw_req_if.sink                          req_ch,
   vdw_rsp_if.source                        rsp_ch
);

   localparam int DEPTH  = SIDE_X * SIDE_Y * SIDE_Z;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [8:0] SIDE_X_L = 9'(SIDE_X);
   localparam logic [8:0] SIDE_Y_L = 9'(SIDE_Y);
   localparam logic [8:0] SIDE_Z_L = 9'(SIDE_Z);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_DRAIN,
      ST_SUM,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic                        bad;
      logic [5:0]                  lo;
      logic [vdw_pkg::FRAC_W-1:0]  frac;
   } axis_type;

   function automatic logic [8:0] eff_size(input logic [vdw_pkg::SIZE_W-1:0] s,
                                           input logic [8:0] side);
      logic [8:0] s9;
      s9 = 9'(s);
      return (s9 < side) ? s9 : side;
   endfunction

   function automatic axis_type axis_eval(input logic [vdw_pkg::POS_W-1:0] pos,
                                          input logic signed [vdw_pkg::DISP_W-1:0] disp,
                                          input logic [8:0] eff);
      logic signed [23:0] p;
      logic [8:0]         lo_next;
      axis_type           r;
      p = $signed({3'b000, pos, 16'h0000}) + 24'(disp);
      lo_next = 9'(p[22:16]) + 9'd1;
      r.bad  = (9'(pos) >= eff) || p[23] || (lo_next >= eff);
      r.lo   = p[21:16];
      r.frac = p[15:0];
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [5:0] x, input logic [5:0] y,
                                                 input logic [5:0] z);
      return ADDR_W'(x) + ADDR_W'(SIDE_X) * (ADDR_W'(y) + ADDR_W'(SIDE_Y) * ADDR_W'(z));
   endfunction

   function automatic logic [vdw_pkg::WGT_W-1:0] weight(input logic upper,
                                                        input logic [vdw_pkg::FRAC_W-1:0] f);
      logic [vdw_pkg::WGT_W-1:0] f17;
      f17 = {1'b0, f};
      return upper ? f17 : vdw_pkg::WEIGHT_ONE - f17;
   endfunction

   state_type state_ff, state_in;
   logic [vdw_pkg::SIZE_W-1:0] size_x_ff, size_x_in, size_y_ff, size_y_in, size_z_ff, size_z_in;
   logic [vdw_pkg::POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic signed [vdw_pkg::DISP_W-1:0] disp_x_ff, disp_x_in, disp_y_ff, disp_y_in;
   logic signed [vdw_pkg::DISP_W-1:0] disp_z_ff, disp_z_in;
   logic [5:0] lo_x_ff, lo_x_in, lo_y_ff, lo_y_in, lo_z_ff, lo_z_in;
   logic [vdw_pkg::FRAC_W-1:0] frac_x_ff, frac_x_in, frac_y_ff, frac_y_in, frac_z_ff, frac_z_in;
   logic [2:0] nbr_ff, nbr_in;
   logic [1:0] phase_ff, phase_in;
   logic signed [vdw_pkg::MUL_P_W-1:0] prod_ff, prod_in;
   logic [23:0] wt_lo_ff, wt_lo_in;
   logic signed [vdw_pkg::ACC_W-1:0] acc_hi_ff, acc_hi_in, acc_lo_ff, acc_lo_in;
   logic signed [vdw_pkg::ACC_W-1:0] sum_ff, sum_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [vdw_pkg::VALUE_W-1:0] warped_ff, warped_in;
   logic in_range_ff, in_range_in;

   logic signed [vdw_pkg::MUL_A_W-1:0] mul_a;
   logic signed [vdw_pkg::MUL_B_W-1:0] mul_b;
   logic signed [vdw_pkg::MUL_P_W-1:0] mul_p;

   logic                             ram_wr_en;
   logic [ADDR_W-1:0]                ram_wr_addr;
   logic                             ram_rd_en;
   logic [ADDR_W-1:0]                ram_rd_addr;
   logic [vdw_pkg::VALUE_W-1:0]      ram_rd_data;

   logic       req_accept;
   logic       out_free;
   axis_type   ax_x, ax_y, ax_z;
   logic [vdw_pkg::WGT_W-1:0] wx, wy, wz;
   logic signed [vdw_pkg::MUL_A_W-1:0] voxel_ext;
   logic signed [36:0] res_wide;
   logic signed [vdw_pkg::VALUE_W-1:0] res_sat;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.warped_value = warped_ff;
   assign rsp_ch.in_range     = in_range_ff;

   assign ax_x = axis_eval(pos_x_ff, disp_x_ff, eff_size(size_x_ff, SIDE_X_L));
   assign ax_y = axis_eval(pos_y_ff, disp_y_ff, eff_size(size_y_ff, SIDE_Y_L));
   assign ax_z = axis_eval(pos_z_ff, disp_z_ff, eff_size(size_z_ff, SIDE_Z_L));

   assign wx = weight(nbr_ff[2], frac_x_ff);
   assign wy = weight(nbr_ff[1], frac_y_ff);
   assign wz = weight(nbr_ff[0], frac_z_ff);

   assign voxel_ext = vdw_pkg::MUL_A_W'($signed(ram_rd_data));
   assign mul_p     = mul_a * mul_b;

   assign res_wide = sum_ff[vdw_pkg::ACC_W-1:24];
   assign res_sat  = (res_wide[36:31] != {6{res_wide[31]}}) ?
                     (res_wide[36] ? 32'sh80000000 : 32'sh7FFFFFFF) : res_wide[31:0];

   always_comb begin
      state_in     = state_ff;
      size_x_in    = size_x_ff;
      size_y_in    = size_y_ff;
      size_z_in    = size_z_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      disp_x_in    = disp_x_ff;
      disp_y_in    = disp_y_ff;
      disp_z_in    = disp_z_ff;
      lo_x_in      = lo_x_ff;
      lo_y_in      = lo_y_ff;
      lo_z_in      = lo_z_ff;
      frac_x_in    = frac_x_ff;
      frac_y_in    = frac_y_ff;
      frac_z_in    = frac_z_ff;
      nbr_in       = nbr_ff;
      phase_in     = phase_ff;
      prod_in      = prod_ff;
      wt_lo_in     = wt_lo_ff;
      acc_hi_in    = acc_hi_ff;
      acc_lo_in    = acc_lo_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      warped_in    = warped_ff;
      in_range_in  = in_range_ff;
      mul_a        = '0;
      mul_b        = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_of({1'b0, req_ch.pos_x}, {1'b0, req_ch.pos_y}, {1'b0, req_ch.pos_z});
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_of(lo_x_ff + 6'(nbr_ff[2]), lo_y_ff + 6'(nbr_ff[1]),
                             lo_z_ff + 6'(nbr_ff[0]));

      if (csr_wr_en) begin
         case (csr_index)
            vdw_pkg::CSR_SIZE_X: size_x_in = csr_wr_data;
            vdw_pkg::CSR_SIZE_Y: size_y_in = csr_wr_data;
            vdw_pkg::CSR_SIZE_Z: size_z_in = csr_wr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_ch.opcode == vdw_pkg::OP_LOAD) begin
                  ram_wr_en = (9'(req_ch.pos_x) < SIDE_X_L) && (9'(req_ch.pos_y) < SIDE_Y_L)
                              && (9'(req_ch.pos_z) < SIDE_Z_L);
               end else begin
                  pos_x_in  = req_ch.pos_x;
                  pos_y_in  = req_ch.pos_y;
                  pos_z_in  = req_ch.pos_z;
                  disp_x_in = req_ch.disp_x;
                  disp_y_in = req_ch.disp_y;
                  disp_z_in = req_ch.disp_z;
                  state_in  = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            lo_x_in   = ax_x.lo;
            lo_y_in   = ax_y.lo;
            lo_z_in   = ax_z.lo;
            frac_x_in = ax_x.frac;
            frac_y_in = ax_y.frac;
            frac_z_in = ax_z.frac;
            nbr_in    = '0;
            phase_in  = '0;
            acc_hi_in = '0;
            acc_lo_in = vdw_pkg::ROUND_HALF;
            if (ax_x.bad || ax_y.bad || ax_z.bad) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  warped_in    = '0;
                  in_range_in  = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            case (phase_ff)
               2'd0: begin
                  mul_a     = vdw_pkg::MUL_A_W'(wx);
                  mul_b     = vdw_pkg::MUL_B_W'(wy);
                  ram_rd_en = 1'b1;
                  if (nbr_ff != 3'd0) begin
                     acc_lo_in = acc_lo_ff + vdw_pkg::ACC_W'(prod_ff);
                  end
               end
               2'd1: begin
                  mul_a = {1'b0, prod_ff[32:0]};
                  mul_b = vdw_pkg::MUL_B_W'(wz);
               end
               2'd2: begin
                  mul_a    = voxel_ext;
                  mul_b    = {1'b0, prod_ff[48:24]};
                  wt_lo_in = prod_ff[23:0];
               end
               default: begin
                  mul_a     = voxel_ext;
                  mul_b     = {2'b00, wt_lo_ff};
                  acc_hi_in = acc_hi_ff + vdw_pkg::ACC_W'(prod_ff);
               end
            endcase
            prod_in  = mul_p;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               nbr_in = nbr_ff + 3'd1;
               if (nbr_ff == 3'd7) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            acc_lo_in = acc_lo_ff + vdw_pkg::ACC_W'(prod_ff);
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = acc_hi_ff + (acc_lo_ff >>> 24);
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               warped_in    = res_sat;
               in_range_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_x_ff    <= vdw_pkg::SIZE_RESET;
         size_y_ff    <= vdw_pkg::SIZE_RESET;
         size_z_ff    <= vdw_pkg::SIZE_RESET;
         nbr_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_x_ff    <= size_x_in;
         size_y_ff    <= size_y_in;
         size_z_ff    <= size_z_in;
         nbr_ff       <= nbr_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      pos_z_ff    <= pos_z_in;
      disp_x_ff   <= disp_x_in;
      disp_y_ff   <= disp_y_in;
      disp_z_ff   <= disp_z_in;
      lo_x_ff     <= lo_x_in;
      lo_y_ff     <= lo_y_in;
      lo_z_ff     <= lo_z_in;
      frac_x_ff   <= frac_x_in;
      frac_y_ff   <= frac_y_in;
      frac_z_ff   <= frac_z_in;
      prod_ff     <= prod_in;
      wt_lo_ff    <= wt_lo_in;
      acc_hi_ff   <= acc_hi_in;
      acc_lo_ff   <= acc_lo_in;
      sum_ff      <= sum_in;
      warped_ff   <= warped_in;
      in_range_ff <= in_range_in;
   end

   vdw_ram #(
      .WIDTH (vdw_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_ch.voxel_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTHESIS
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !in_range_ff) |-> (warped_ff == '0))
      else $error("out-of-range response carries a nonzero value");

   a_warp_drops_ready: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.opcode == vdw_pkg::OP_WARP) |=> !req_ch.ready)
      else $error("ready stayed high after a warp word was accepted");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_IDLE && !ram_rd_en))
      else $error("store written outside the idle state");

   a_response_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff == ST_CHECK) || $past(state_ff == ST_FINAL)))
      else $error("response raised outside the check or final step");

   a_drain_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> ($past(state_ff == ST_RUN) && nbr_ff == 3'd0 &&
                                  phase_ff == 2'd0))
      else $error("drain step entered before all neighbours were processed");
`endif

endmodule

`default_nettype wire

@@ test/warp_blend_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts every warped voxel word and compares it with the response channel.
module warp_blend_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [vdw_pkg::SIZE_W-1:0] csr_wr_data,
   vdw_req_if                              req_ch,
   vdw_rsp_if                              rsp_ch,
   output int                              mismatches,
   output int                              pending
);

   localparam int SIDE = 32;
   localparam logic signed [95:0] ROUND_BIAS = 96'sd1 <<< 47;
   localparam logic signed [95:0] VALUE_MAX = 96'sd2147483647;
   localparam logic signed [95:0] VALUE_MIN = -96'sd2147483648;

   typedef struct packed {
      logic signed [vdw_pkg::VALUE_W-1:0] warped_value;
      logic                               in_range;
   } warp_result_type;

   bit signed [vdw_pkg::VALUE_W-1:0] voxels [0:SIDE*SIDE*SIDE-1];
   int                               extent [3];
   warp_result_type                  expected_voxels [$];

   function automatic int voxel_addr(input int x, input int y, input int z);
      return x + SIDE * (y + SIDE * z);
   endfunction

   function automatic warp_result_type predict_warp(
         input logic [vdw_pkg::POS_W-1:0] px, py, pz,
         input logic signed [vdw_pkg::DISP_W-1:0] dx, dy, dz);
      int                 coord [3];
      int                 shift [3];
      int                 corner [3];
      int                 frac [3];
      int                 lim;
      int                 p;
      int                 ax;
      int                 c;
      longint             wt;
      logic signed [95:0] acc;
      logic signed [95:0] term;
      logic signed [95:0] rounded;
      warp_result_type    r;
      bit                 in_volume;
      coord = '{int'(px), int'(py), int'(pz)};
      shift = '{int'(dx), int'(dy), int'(dz)};
      in_volume = 1'b1;
      for (ax = 0; ax < 3; ax++) begin
         lim = (extent[ax] < SIDE) ? extent[ax] : SIDE;
         p = coord[ax] * 65536 + shift[ax];
         corner[ax] = p >>> vdw_pkg::FRAC_W;
         frac[ax] = p & 16'hFFFF;
         if (coord[ax] >= lim || corner[ax] < 0 || corner[ax] + 1 >= lim) begin
            in_volume = 1'b0;
         end
      end
      r.warped_value = '0;
      r.in_range = 1'b0;
      if (!in_volume) begin
         return r;
      end
      acc = '0;
      for (c = 0; c < 8; c++) begin
         wt = longint'(c[2] ? frac[0] : 65536 - frac[0])
            * longint'(c[1] ? frac[1] : 65536 - frac[1])
            * longint'(c[0] ? frac[2] : 65536 - frac[2]);
         term = 96'(voxels[voxel_addr(corner[0] + c[2], corner[1] + c[1], corner[2] + c[0])]);
         term = term * wt;
         acc = acc + term;
      end
      rounded = (acc + ROUND_BIAS) >>> 48;
      if (rounded > VALUE_MAX) begin
         r.warped_value = 32'sh7FFFFFFF;
      end else if (rounded < VALUE_MIN) begin
         r.warped_value = 32'sh80000000;
      end else begin
         r.warped_value = rounded[vdw_pkg::VALUE_W-1:0];
      end
      r.in_range = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      warp_result_type want;
      int              bad;
      bad = 0;
      if (reset) begin
         extent = '{int'(vdw_pkg::SIZE_RESET), int'(vdw_pkg::SIZE_RESET),
                    int'(vdw_pkg::SIZE_RESET)};
         expected_voxels.delete();
         mismatches <= 0;
      end else begin
         if (csr_wr_en) begin
            case (vdw_pkg::csr_index_type'(csr_index))
               vdw_pkg::CSR_SIZE_X: extent[0] = int'(csr_wr_data);
               vdw_pkg::CSR_SIZE_Y: extent[1] = int'(csr_wr_data);
               vdw_pkg::CSR_SIZE_Z: extent[2] = int'(csr_wr_data);
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.opcode == vdw_pkg::OP_LOAD) begin
               voxels[voxel_addr(int'(req_ch.pos_x), int'(req_ch.pos_y), int'(req_ch.pos_z))]
                  = req_ch.voxel_value;
            end else begin
               expected_voxels.push_back(predict_warp(req_ch.pos_x, req_ch.pos_y, req_ch.pos_z,
                                                      req_ch.disp_x, req_ch.disp_y, req_ch.disp_z));
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_voxels.size() == 0) begin
               $error("Response word arrived with no warp waiting.");
               bad++;
            end else begin
               want = expected_voxels.pop_front();
               if (rsp_ch.warped_value !== want.warped_value) begin
                  $error("warped_value: expected %0d, actual %0d", want.warped_value,
                         rsp_ch.warped_value);
                  bad++;
               end
               if (rsp_ch.in_range !== want.in_range) begin
                  $error("in_range: expected %0d, actual %0d", want.in_range, rsp_ch.in_range);
                  bad++;
               end
            end
         end
         mismatches <= mismatches + bad;
      end
      pending <= expected_voxels.size();
   end

endmodule

@@ test/volume_displacement_warp_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the volume displacement warp: clock, reset, stimulus and the verdict.
module volume_displacement_warp_tb;

   localparam int SIDE = 32;
   localparam int LATENCY = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int PHASES = 10;
   localparam int FIXED_PHASES = 7;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [1:0]                 csr_index = '0;
   logic [vdw_pkg::SIZE_W-1:0] csr_wr_data = '0;

   vdw_req_if req_ch ();
   vdw_rsp_if rsp_ch ();

   int mismatches;
   int pending;
   int items_sent = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   bit idle_on = 1'b1;
   int eff [3];
   bit loaded [0:SIDE*SIDE*SIDE-1];
   int phase_table [FIXED_PHASES][3] = '{'{2, 2, 2}, '{3, 4, 5}, '{32, 32, 32}, '{0, 1, 2},
                                         '{63, 33, 40}, '{6, 2, 31}, '{1, 63, 3}};

   volume_displacement_warp dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   warp_blend_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 14);
         rsp_ch.ready <= 1'b0;
      end else begin
         stall_left <= 0;
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_ch.valid && req_ch.ready)
          || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [vdw_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 131071) - 65536;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic op, input logic [vdw_pkg::POS_W-1:0] x, y, z,
                            input logic [vdw_pkg::VALUE_W-1:0] value,
                            input logic [vdw_pkg::DISP_W-1:0] dx, dy, dz);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.pos_x <= x;
      req_ch.pos_y <= y;
      req_ch.pos_z <= z;
      req_ch.voxel_value <= value;
      req_ch.disp_x <= dx;
      req_ch.disp_y <= dy;
      req_ch.disp_z <= dz;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_voxel(input int x, input int y, input int z,
                             input logic [vdw_pkg::VALUE_W-1:0] v);
      loaded[x + SIDE * (y + SIDE * z)] = 1'b1;
      send_word(vdw_pkg::OP_LOAD, vdw_pkg::POS_W'(x), vdw_pkg::POS_W'(y), vdw_pkg::POS_W'(z), v,
                vdw_pkg::DISP_W'($urandom), vdw_pkg::DISP_W'($urandom),
                vdw_pkg::DISP_W'($urandom));
   endtask

   // Any neighbor cube that the block could read is loaded first, so no unwritten
   // voxel is ever part of a blend.
   task automatic warp_voxel(input int x, input int y, input int z, input int dx, input int dy,
                             input int dz);
      logic signed [vdw_pkg::DISP_W-1:0] shift [3];
      int                                coord [3];
      int                                corner [3];
      int                                ax;
      int                                c;
      int                                idx;
      bit                                reachable;
      shift = '{vdw_pkg::DISP_W'(dx), vdw_pkg::DISP_W'(dy), vdw_pkg::DISP_W'(dz)};
      coord = '{x, y, z};
      reachable = 1'b1;
      for (ax = 0; ax < 3; ax++) begin
         corner[ax] = (coord[ax] * 65536 + int'(shift[ax])) >>> vdw_pkg::FRAC_W;
         if (corner[ax] < 0 || corner[ax] > SIDE - 2) begin
            reachable = 1'b0;
         end
      end
      if (reachable) begin
         for (c = 0; c < 8; c++) begin
            idx = corner[0] + c[2] + SIDE * (corner[1] + c[1] + SIDE * (corner[2] + c[0]));
            if (!loaded[idx]) begin
               load_voxel(corner[0] + c[2], corner[1] + c[1], corner[2] + c[0], pick_value());
            end
         end
      end
      send_word(vdw_pkg::OP_WARP, vdw_pkg::POS_W'(x), vdw_pkg::POS_W'(y), vdw_pkg::POS_W'(z),
                $urandom, shift[0], shift[1], shift[2]);
   endtask

   task automatic random_item();
      int pick;
      int ax;
      int lo;
      int frac;
      int coord [3];
      int shift [3];
      pick = $urandom_range(0, 99);
      if (pick < 60 && eff[0] >= 2 && eff[1] >= 2 && eff[2] >= 2) begin
         for (ax = 0; ax < 3; ax++) begin
            lo = $urandom_range(0, eff[ax] - 2);
            coord[ax] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SIDE - 1)
                                                     : $urandom_range(0, eff[ax] - 1);
            case ($urandom_range(0, 5))
               0: frac = 0;
               1: frac = 16'h8000;
               2: frac = 16'hFFFF;
               default: frac = $urandom_range(0, 65535);
            endcase
            shift[ax] = (lo - coord[ax]) * 65536 + frac;
         end
         warp_voxel(coord[0], coord[1], coord[2], shift[0], shift[1], shift[2]);
      end else if (pick < 85) begin
         warp_voxel($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                    $urandom_range(0, SIDE - 1), $urandom, $urandom, $urandom);
      end else begin
         load_voxel($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                    $urandom_range(0, SIDE - 1), pick_value());
      end
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic program_sizes(input logic [vdw_pkg::SIZE_W-1:0] sx, sy, sz);
      csr_wr_en <= 1'b1;
      csr_index <= vdw_pkg::CSR_SIZE_X;
      csr_wr_data <= sx;
      @(posedge clock);
      csr_index <= vdw_pkg::CSR_SIZE_Y;
      csr_wr_data <= sy;
      @(posedge clock);
      csr_index <= vdw_pkg::CSR_SIZE_Z;
      csr_wr_data <= sz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      eff[0] = (int'(sx) < SIDE) ? int'(sx) : SIDE;
      eff[1] = (int'(sy) < SIDE) ? int'(sy) : SIDE;
      eff[2] = (int'(sz) < SIDE) ? int'(sz) : SIDE;
   endtask

   task automatic directed_words();
      load_voxel(0, 0, 0, 32'h7FFFFFFF);
      load_voxel(1, 0, 0, 32'h80000000);
      load_voxel(0, 1, 0, 32'h00000000);
      load_voxel(1, 1, 0, 32'hFFFFFFFF);
      load_voxel(0, 0, 1, 32'h00010000);
      load_voxel(1, 0, 1, 32'h7FFFFFFF);
      load_voxel(0, 1, 1, 32'h80000001);
      load_voxel(1, 1, 1, 32'h12345678);
      warp_voxel(0, 0, 0, 0, 0, 0);
      warp_voxel(0, 0, 0, 32768, 32768, 32768);
      warp_voxel(0, 0, 0, 1, 65535, 32767);
      // A lower corner just below zero and an upper corner at the size both miss.
      warp_voxel(0, 0, 0, -1, 0, 0);
      warp_voxel(SIDE - 1, SIDE - 1, SIDE - 1, 0, 0, 0);
      warp_voxel(SIDE - 1, SIDE - 1, SIDE - 1, -65536, -65536, -65536);
      warp_voxel(SIDE - 1, SIDE - 1, SIDE - 1, -49152, -49152, -49152);
      warp_voxel(0, 0, 0, 2097151, 0, 0);
      warp_voxel(SIDE - 1, SIDE - 1, SIDE - 1, -2097152, -2097152, -2097152);
   endtask

   initial begin
      int                         ph;
      int                         ax;
      int                         budget_end;
      logic [vdw_pkg::SIZE_W-1:0] sizes [3];
      req_ch.valid = 1'b0;
      req_ch.opcode = vdw_pkg::OP_LOAD;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      req_ch.voxel_value = '0;
      req_ch.disp_x = '0;
      req_ch.disp_y = '0;
      req_ch.disp_z = '0;
      eff = '{SIDE, SIDE, SIDE};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      directed_words();
      for (ph = 0; ph < PHASES; ph++) begin
         for (ax = 0; ax < 3; ax++) begin
            if (ph < FIXED_PHASES) begin
               sizes[ax] = vdw_pkg::SIZE_W'(phase_table[ph][ax]);
            end else begin
               sizes[ax] = ($urandom_range(0, 7) == 0) ? vdw_pkg::SIZE_W'($urandom_range(0, 63))
                                                        : vdw_pkg::SIZE_W'($urandom_range(2, 8));
            end
         end
         settle();
         program_sizes(sizes[0], sizes[1], sizes[2]);
         idle_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         budget_end = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < budget_end) random_item();
      end
      settle();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
